@@ src/multitouch_slot_event_decoder_core_defines.svh @@
// Assertion macros shared by the multitouch decoder checker
`ifndef MULTITOUCH_SLOT_EVENT_DECODER_CORE_DEFINES_SVH
`define MULTITOUCH_SLOT_EVENT_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted
`define MSED_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define MSED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds through reset
`define MSED_ASSERT_RST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/msed_pkg.sv @@
// Types and constants of the multitouch slot event decoder
package msed_pkg;

  localparam int TYPE_W  = 16;
  localparam int CODE_W  = 16;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 12;
  localparam int FINGER_W = 3;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;

  // Event classes and codes
  localparam logic [TYPE_W-1:0] TYPE_SYN = 16'h0000;
  localparam logic [TYPE_W-1:0] TYPE_ABS = 16'h0003;
  localparam logic [CODE_W-1:0] CODE_REPORT = 16'h0000;
  localparam logic [CODE_W-1:0] CODE_SLOT   = 16'h002f;
  localparam logic [CODE_W-1:0] CODE_POS_X  = 16'h0035;
  localparam logic [CODE_W-1:0] CODE_POS_Y  = 16'h0036;
  localparam logic [CODE_W-1:0] CODE_TRACK  = 16'h0039;

  localparam logic [VALUE_W-1:0] TRACK_RELEASE = 32'hffff_ffff;
  localparam logic [POS_W-1:0]   POS_MAX       = 12'hfff;

  // Queue between classifier and executor
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_MOVE    = 2'd2,
    KIND_RELEASE = 2'd3
  } touch_kind_t;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_SLOT    = 3'd1,
    OP_RELEASE = 3'd2,
    OP_PRESS   = 3'd3,
    OP_POS_X   = 3'd4,
    OP_POS_Y   = 3'd5,
    OP_REPORT  = 3'd6
  } op_kind_t;

  // Classified event: arg is a saturated position or an in-range slot number
  typedef struct packed {
    op_kind_t          kind;
    logic [POS_W-1:0]  arg;
  } op_t;

endpackage

@@ src/multitouch_slot_event_decoder_core.sv @@
// Top level of the multitouch slot event decoder
//
//   port group | dir | beat contents (low bit first)
//   in_        | in  | event_type[15:0], event_code[31:16], event_value[63:32]
//   out_       | out | touch_kind[1:0], pos_x[13:2], pos_y[25:14], finger_index[28:26]
//
// One event per clock sustained while out_tready is high; each beat gives exactly
// one result beat. An accepted beat is registered in the 4-entry operation queue;
// the slot table update and the result register load then happen in the same cycle.
// Reset clears the current slot, all positions and pending kinds at once.
// Output stalls fill the queue; in_tready drops only when it is full.
module multitouch_slot_event_decoder_core
  import msed_pkg::*;
#(
  parameter int SLOTS = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // event_type[15:0], event_code[31:16], event_value[63:32]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // touch_kind[1:0], pos_x[13:2], pos_y[25:14], finger_index[28:26], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  op_t  front_op;
  op_t  back_op;
  logic back_valid;
  logic back_ready;

  msed_front #(.SLOTS(SLOTS)) u_front (
    .event_type  (in_tdata[15:0]),
    .event_code  (in_tdata[31:16]),
    .event_value (in_tdata[63:32]),
    .op          (front_op)
  );

  msed_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_op    (front_op),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_op     (back_op)
  );

  msed_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (back_valid),
    .op_ready  (back_ready),
    .op        (back_op),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

@@ src/msed_front.sv @@
// Front end: decode one input beat into an executor operation
module msed_front
  import msed_pkg::*;
#(
  parameter int SLOTS = 5
) (
  input  logic [TYPE_W-1:0]  event_type,
  input  logic [CODE_W-1:0]  event_code,
  input  logic [VALUE_W-1:0] event_value,
  output op_t                op
);

  logic             slot_ok;
  logic [POS_W-1:0] pos_sat;

  // Range check for a slot selection: non-negative and below SLOTS
  assign slot_ok = !event_value[VALUE_W-1] &&
                   (event_value[VALUE_W-2:0] < (VALUE_W-1)'(SLOTS));

  // Clamp the coordinate to 0..POS_MAX
  always_comb begin
    if (event_value[VALUE_W-1]) begin
      pos_sat = '0;
    end else if (|event_value[VALUE_W-2:POS_W]) begin
      pos_sat = POS_MAX;
    end else begin
      pos_sat = event_value[POS_W-1:0];
    end
  end

  // Classify type and code
  always_comb begin
    op.kind = OP_NOP;
    op.arg  = '0;
    if (event_type == TYPE_ABS) begin
      case (event_code)
        CODE_SLOT: begin
          if (slot_ok) begin
            op.kind = OP_SLOT;
            op.arg  = event_value[POS_W-1:0];
          end
        end
        CODE_TRACK: begin
          op.kind = (event_value == TRACK_RELEASE) ? OP_RELEASE : OP_PRESS;
        end
        CODE_POS_X: begin
          op.kind = OP_POS_X;
          op.arg  = pos_sat;
        end
        CODE_POS_Y: begin
          op.kind = OP_POS_Y;
          op.arg  = pos_sat;
        end
        default: begin
          op.kind = OP_NOP;
        end
      endcase
    end else if (event_type == TYPE_SYN && event_code == CODE_REPORT) begin
      op.kind = OP_REPORT;
    end
  end

endmodule

@@ src/msed_queue.sv @@
// Short queue of classified operations between front and back end
module msed_queue
  import msed_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_op
);

  op_t               entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

@@ src/msed_back.sv @@
// Back end: slot table update and result register
module msed_back
  import msed_pkg::*;
#(
  parameter int SLOTS = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  op_valid,
  output logic                  op_ready,
  input  op_t                   op,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [POS_W-1:0]  x_r [SLOTS];
  logic [POS_W-1:0]  y_r [SLOTS];
  touch_kind_t       pend_r [SLOTS];
  touch_kind_t       pend_cur, pend_new;
  logic              pend_we, x_we, y_we;
  touch_kind_t       res_kind;
  logic              take;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  assign op_ready  = !out_valid_r || out_ready;
  assign take      = op_valid && op_ready;
  assign pend_cur  = pend_r[cur_r];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Execute one operation against the current slot
  always_comb begin
    cur_nxt  = cur_r;
    pend_new = pend_cur;
    pend_we  = 1'b0;
    x_we     = 1'b0;
    y_we     = 1'b0;
    res_kind = KIND_NONE;
    case (op.kind)
      OP_SLOT: begin
        cur_nxt  = op.arg[SLOT_W-1:0];
        res_kind = pend_cur;
        pend_new = KIND_NONE;
        pend_we  = 1'b1;
      end
      OP_REPORT: begin
        res_kind = pend_cur;
        pend_new = KIND_NONE;
        pend_we  = 1'b1;
      end
      OP_RELEASE: begin
        res_kind = KIND_RELEASE;
        pend_new = KIND_NONE;
        pend_we  = 1'b1;
      end
      OP_PRESS: begin
        pend_new = KIND_PRESS;
        pend_we  = 1'b1;
      end
      OP_POS_X, OP_POS_Y: begin
        x_we     = (op.kind == OP_POS_X);
        y_we     = (op.kind == OP_POS_Y);
        pend_new = (pend_cur == KIND_PRESS) ? KIND_PRESS : KIND_MOVE;
        pend_we  = 1'b1;
      end
      default: begin
        res_kind = KIND_NONE;
      end
    endcase
  end

  // Pack the result beat; no event carries zeros
  always_comb begin
    out_data_nxt = '0;
    if (res_kind != KIND_NONE) begin
      out_data_nxt[1:0]   = res_kind;
      out_data_nxt[13:2]  = x_r[cur_r];
      out_data_nxt[25:14] = y_r[cur_r];
      out_data_nxt[28:26] = FINGER_W'(cur_r);
    end
  end

  // Hold control state and the per-slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        x_r[i]    <= '0;
        y_r[i]    <= '0;
        pend_r[i] <= KIND_NONE;
      end
    end else begin
      if (take) begin
        cur_r       <= cur_nxt;
        out_valid_r <= 1'b1;
        if (pend_we) begin
          pend_r[cur_r] <= pend_new;
        end
        if (x_we) begin
          x_r[cur_r] <= op.arg;
        end
        if (y_we) begin
          y_r[cur_r] <= op.arg;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

@@ src/msed_checker.sv @@
// Port-level checks for the multitouch slot event decoder, with bind
`include "multitouch_slot_event_decoder_core_defines.svh"

module msed_checker #(
  parameter int SLOTS = 5
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // A stalled result beat holds its value
  `MSED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // No-event beats carry zero position and finger, pad bits are zero
  `MSED_ASSERT_NOW(a_none_zero, clk, rst_n, out_tvalid && (out_tdata[1:0] == 2'd0), out_tdata[31:2] == 30'd0, "no-event beat carries data")

  // Reported finger is a real slot
  `MSED_ASSERT_NOW(a_finger_range, clk, rst_n, out_tvalid && (out_tdata[1:0] != 2'd0), (out_tdata[31:29] == 3'd0) && ({29'd0, out_tdata[28:26]} < SLOTS), "finger out of range")

  // Nothing is offered straight out of reset
  `MSED_ASSERT_RST(a_reset_idle, clk, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind multitouch_slot_event_decoder_core msed_checker #(.SLOTS(SLOTS)) u_msed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
